// ===== rtl/sda_pkg.sv =====
// ----------------------------------------------------------------------------
// sda_pkg
// shared types, widths and helpers for the split/dividend back adjuster
// ----------------------------------------------------------------------------
package sda_pkg;

    localparam int PRICE_BITS      = 40;
    localparam int VOL_BITS        = 48;
    localparam int CASH_BITS       = 40;
    localparam int AMT_BITS        = 32;
    localparam int RATIO_BITS      = 32;
    localparam int RATIO_FRAC_BITS = 16;
    localparam int SCALE_BITS      = 64;
    localparam int SCALE_FRAC_BITS = 48;
    localparam int WIDE_BITS       = 2 * SCALE_BITS;
    localparam int HALF_BITS       = SCALE_BITS / 2;
    localparam int DIV_STEPS       = WIDE_BITS;
    localparam int MUL_STEPS       = 4;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(1) << SCALE_FRAC_BITS;

    typedef enum logic [1:0] {
        MODE_BAR   = 2'd0,
        MODE_CASH  = 2'd1,
        MODE_SPLIT = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        K_BAR       = 2'd0,
        K_BAR_FIRST = 2'd1,
        K_CASH      = 2'd2,
        K_SPLIT     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        FAULT_OK    = 2'd0,
        FAULT_SPLIT = 2'd1,
        FAULT_CLOSE = 2'd2
    } t_fault;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_NEXT,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        ST_SPLIT,
        ST_CMUL,
        ST_CDIV,
        ST_SDIV,
        ST_VMUL,
        ST_OPEN,
        ST_HIGH,
        ST_LOW,
        ST_CLOSE,
        ST_VOL
    } t_step;

    typedef struct packed {
        t_kind                  kind;
        logic [PRICE_BITS-1:0]  open_price;
        logic [PRICE_BITS-1:0]  high_price;
        logic [PRICE_BITS-1:0]  low_price;
        logic [PRICE_BITS-1:0]  close_price;
        logic [VOL_BITS-1:0]    share_volume;
        logic [AMT_BITS-1:0]    cash_amount;
        logic [RATIO_BITS-1:0]  split_ratio;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_qhead;

    // clamp a wide unsigned value to the factor range
    function automatic logic [SCALE_BITS-1:0] sat_scale(input logic [WIDE_BITS-1:0] v);
        sat_scale = (v[WIDE_BITS-1:SCALE_BITS] != '0) ? '1 : v[SCALE_BITS-1:0];
    endfunction

    function automatic logic [PRICE_BITS-1:0] sat_price(input logic [WIDE_BITS-1:0] v);
        sat_price = (v[WIDE_BITS-1:PRICE_BITS] != '0) ? '1 : v[PRICE_BITS-1:0];
    endfunction

    function automatic logic [VOL_BITS-1:0] sat_vol(input logic [WIDE_BITS-1:0] v);
        sat_vol = (v[WIDE_BITS-1:VOL_BITS] != '0) ? '1 : v[VOL_BITS-1:0];
    endfunction

endpackage

// ===== rtl/sda_front.sv =====
// ----------------------------------------------------------------------------
// sda_front
// accepts beats, classifies them and queues the ones that matter
// ----------------------------------------------------------------------------
module sda_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [1:0]                         i_mode,
    input  logic [sda_pkg::PRICE_BITS-1:0]     i_open_price,
    input  logic [sda_pkg::PRICE_BITS-1:0]     i_high_price,
    input  logic [sda_pkg::PRICE_BITS-1:0]     i_low_price,
    input  logic [sda_pkg::PRICE_BITS-1:0]     i_close_price,
    input  logic [sda_pkg::VOL_BITS-1:0]       i_share_volume,
    input  logic [sda_pkg::AMT_BITS-1:0]       i_cash_amount,
    input  logic [sda_pkg::RATIO_BITS-1:0]     i_split_ratio,
    output sda_pkg::t_qhead                    o_head,
    input  logic                               i_pop
);

    sda_pkg::t_item r_q [sda_pkg::QUEUE_DEPTH];
    logic           r_wr, n_wr;
    logic           r_rd, n_rd;
    logic [1:0]     r_cnt, n_cnt;
    logic           r_seen, n_seen;
    logic           w_acc;
    logic           w_push;
    sda_pkg::t_item w_item;

    assign o_ready = (r_cnt != 2'(sda_pkg::QUEUE_DEPTH));
    assign w_acc   = i_valid && o_ready;

    // events before the first bar and unused modes never enter the queue
    always_comb begin
        w_item.open_price   = i_open_price;
        w_item.high_price   = i_high_price;
        w_item.low_price    = i_low_price;
        w_item.close_price  = i_close_price;
        w_item.share_volume = i_share_volume;
        w_item.cash_amount  = i_cash_amount;
        w_item.split_ratio  = i_split_ratio;
        w_item.kind         = sda_pkg::K_BAR;
        w_push              = 1'b0;
        n_seen              = r_seen;
        case (sda_pkg::t_mode'(i_mode))
            sda_pkg::MODE_BAR: begin
                w_item.kind = r_seen ? sda_pkg::K_BAR : sda_pkg::K_BAR_FIRST;
                w_push      = w_acc;
                n_seen      = r_seen || w_acc;
            end
            sda_pkg::MODE_CASH: begin
                w_item.kind = sda_pkg::K_CASH;
                w_push      = w_acc && r_seen;
            end
            sda_pkg::MODE_SPLIT: begin
                w_item.kind = sda_pkg::K_SPLIT;
                w_push      = w_acc && r_seen;
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_wr  = w_push ? ~r_wr : r_wr;
        n_rd  = i_pop ? ~r_rd : r_rd;
        n_cnt = r_cnt + 2'(w_push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_cnt  <= '0;
            r_seen <= 1'b0;
        end else begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_cnt  <= n_cnt;
            r_seen <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= w_item;
        end
    end

    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_q[r_rd];

endmodule

// ===== rtl/sda_back.sv =====
// ----------------------------------------------------------------------------
// sda_back
// sequencer with a shared 32x32 multiplier and a radix-2 divider
// ----------------------------------------------------------------------------
module sda_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sda_pkg::t_qhead                    i_head,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [sda_pkg::PRICE_BITS-1:0]     o_adj_open,
    output logic [sda_pkg::PRICE_BITS-1:0]     o_adj_high,
    output logic [sda_pkg::PRICE_BITS-1:0]     o_adj_low,
    output logic [sda_pkg::PRICE_BITS-1:0]     o_adj_close,
    output logic [sda_pkg::VOL_BITS-1:0]       o_adj_volume,
    output logic [1:0]                         o_fault
);

    localparam int SW = sda_pkg::SCALE_BITS;
    localparam int WW = sda_pkg::WIDE_BITS;
    localparam int HW = sda_pkg::HALF_BITS;
    localparam int PB = sda_pkg::PRICE_BITS;
    localparam int VB = sda_pkg::VOL_BITS;
    localparam int CB = sda_pkg::CASH_BITS;

    sda_pkg::t_state r_state, n_state;
    sda_pkg::t_step  r_step, n_step;
    sda_pkg::t_item  r_item, n_item;
    sda_pkg::t_fault r_fault, n_fault;

    logic [PB-1:0]   r_prior, n_prior;
    logic [CB-1:0]   r_cash, n_cash;
    logic [SW-1:0]   r_psplit, n_psplit;
    logic [SW-1:0]   r_pscale, n_pscale;
    logic [SW-1:0]   r_vscale, n_vscale;
    logic [SW-1:0]   r_newp, n_newp;

    logic [SW-1:0]   r_ma, n_ma;
    logic [SW-1:0]   r_mb, n_mb;
    logic [2:0]      r_mcnt, n_mcnt;
    logic [SW-1:0]   r_pp, n_pp;
    logic [1:0]      r_psh, n_psh;
    logic [WW-1:0]   r_acc, n_acc;

    logic [WW-1:0]   r_dvd, n_dvd;
    logic [SW-1:0]   r_rem, n_rem;
    logic [WW-1:0]   r_quo, n_quo;
    logic [SW-1:0]   r_dvs, n_dvs;
    logic [6:0]      r_dcnt, n_dcnt;

    logic [PB-1:0]   r_res_open, n_res_open;
    logic [PB-1:0]   r_res_high, n_res_high;
    logic [PB-1:0]   r_res_low, n_res_low;
    logic [PB-1:0]   r_res_close, n_res_close;
    logic [VB-1:0]   r_res_vol, n_res_vol;

    logic            r_ovalid, n_ovalid;
    logic [PB-1:0]   r_o_open, n_o_open;
    logic [PB-1:0]   r_o_high, n_o_high;
    logic [PB-1:0]   r_o_low, n_o_low;
    logic [PB-1:0]   r_o_close, n_o_close;
    logic [VB-1:0]   r_o_vol, n_o_vol;
    logic [1:0]      r_o_fault, n_o_fault;

    logic [CB+1:0]   w_den;
    sda_pkg::t_fault w_fault;
    logic            w_cash_nz;
    logic [CB:0]     w_csum;
    logic [HW-1:0]   w_ma_part, w_mb_part;
    logic [SW:0]     w_remn;
    logic            w_take;
    logic            w_out_free;
    logic [SW-1:0]   w_q;

    // fault check for a bar after the first
    always_comb begin
        w_cash_nz = (r_cash != '0);
        w_den     = {2'b00, r_prior} + {{2{r_cash[CB-1]}}, r_cash};
        if (r_psplit == '0) begin
            w_fault = sda_pkg::FAULT_SPLIT;
        end else if (w_cash_nz && ((r_prior == '0) || w_den[CB+1] || (w_den == '0))) begin
            w_fault = sda_pkg::FAULT_CLOSE;
        end else begin
            w_fault = sda_pkg::FAULT_OK;
        end
        w_csum = {r_cash[CB-1], r_cash} + (CB+1)'($signed(r_item.cash_amount));
    end

    assign w_ma_part  = r_mcnt[1] ? r_ma[SW-1:HW] : r_ma[HW-1:0];
    assign w_mb_part  = r_mcnt[0] ? r_mb[SW-1:HW] : r_mb[HW-1:0];
    assign w_remn     = {1'b0, r_rem[SW-2:0], r_dvd[WW-1]};
    assign w_take     = r_rem[SW-1] || (w_remn >= {1'b0, r_dvs});
    assign w_out_free = !r_ovalid || i_ready;
    assign w_q        = sda_pkg::sat_scale(r_quo);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sda_pkg::S_IDLE: begin
                if (i_head.valid) begin
                    n_state = sda_pkg::S_EXEC;
                end
            end
            sda_pkg::S_EXEC: begin
                case (r_item.kind)
                    sda_pkg::K_CASH:      n_state = sda_pkg::S_IDLE;
                    sda_pkg::K_SPLIT:     n_state = sda_pkg::S_MUL;
                    sda_pkg::K_BAR_FIRST: n_state = sda_pkg::S_MUL;
                    sda_pkg::K_BAR: begin
                        if (w_fault != sda_pkg::FAULT_OK || w_cash_nz) begin
                            n_state = sda_pkg::S_MUL;
                        end else begin
                            n_state = sda_pkg::S_DIV;
                        end
                    end
                    default: n_state = sda_pkg::S_IDLE;
                endcase
            end
            sda_pkg::S_MUL: begin
                if (r_mcnt == 3'(sda_pkg::MUL_STEPS)) begin
                    n_state = sda_pkg::S_NEXT;
                end
            end
            sda_pkg::S_DIV: begin
                if (r_dcnt == 7'(sda_pkg::DIV_STEPS - 1)) begin
                    n_state = sda_pkg::S_NEXT;
                end
            end
            sda_pkg::S_NEXT: begin
                case (r_step)
                    sda_pkg::ST_SPLIT: n_state = sda_pkg::S_IDLE;
                    sda_pkg::ST_CMUL:  n_state = sda_pkg::S_DIV;
                    sda_pkg::ST_CDIV:  n_state = sda_pkg::S_DIV;
                    sda_pkg::ST_VOL:   n_state = sda_pkg::S_OUT;
                    default:           n_state = sda_pkg::S_MUL;
                endcase
            end
            sda_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_state = sda_pkg::S_IDLE;
                end
            end
            default: n_state = sda_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_step      = r_step;
        n_item      = r_item;
        n_fault     = r_fault;
        n_prior     = r_prior;
        n_cash      = r_cash;
        n_psplit    = r_psplit;
        n_pscale    = r_pscale;
        n_vscale    = r_vscale;
        n_newp      = r_newp;
        n_ma        = r_ma;
        n_mb        = r_mb;
        n_mcnt      = r_mcnt;
        n_pp        = r_pp;
        n_psh       = r_psh;
        n_acc       = r_acc;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_dvs       = r_dvs;
        n_dcnt      = r_dcnt;
        n_res_open  = r_res_open;
        n_res_high  = r_res_high;
        n_res_low   = r_res_low;
        n_res_close = r_res_close;
        n_res_vol   = r_res_vol;
        n_ovalid    = r_ovalid && !i_ready;
        n_o_open    = r_o_open;
        n_o_high    = r_o_high;
        n_o_low     = r_o_low;
        n_o_close   = r_o_close;
        n_o_vol     = r_o_vol;
        n_o_fault   = r_o_fault;
        o_pop       = 1'b0;

        case (r_state)
            sda_pkg::S_IDLE: begin
                o_pop = i_head.valid;
                if (i_head.valid) begin
                    n_item = i_head.item;
                end
            end
            sda_pkg::S_EXEC: begin
                n_mcnt = '0;
                n_acc  = '0;
                case (r_item.kind)
                    sda_pkg::K_CASH: begin
                        // saturate to the signed accumulator range
                        if (w_csum[CB] != w_csum[CB-1]) begin
                            n_cash = {w_csum[CB], {(CB-1){~w_csum[CB]}}};
                        end else begin
                            n_cash = w_csum[CB-1:0];
                        end
                    end
                    sda_pkg::K_SPLIT: begin
                        n_step = sda_pkg::ST_SPLIT;
                        n_ma   = r_psplit;
                        n_mb   = SW'(r_item.split_ratio);
                    end
                    sda_pkg::K_BAR_FIRST: begin
                        n_fault = sda_pkg::FAULT_OK;
                        n_step  = sda_pkg::ST_OPEN;
                        n_ma    = SW'(r_item.open_price);
                        n_mb    = r_pscale;
                    end
                    default: begin
                        n_fault = w_fault;
                        if (w_fault != sda_pkg::FAULT_OK) begin
                            n_step = sda_pkg::ST_OPEN;
                            n_ma   = SW'(r_item.open_price);
                            n_mb   = r_pscale;
                        end else if (w_cash_nz) begin
                            n_step = sda_pkg::ST_CMUL;
                            n_ma   = r_pscale;
                            n_mb   = SW'(r_prior);
                        end else begin
                            // no cash: the price ratio is one
                            n_step = sda_pkg::ST_SDIV;
                            n_dvd  = WW'(r_pscale) << sda_pkg::SCALE_FRAC_BITS;
                            n_rem  = '0;
                            n_quo  = '0;
                            n_dvs  = r_psplit;
                            n_dcnt = '0;
                        end
                    end
                endcase
            end
            sda_pkg::S_MUL: begin
                // partial product registered, added in the following cycle
                if (r_mcnt != 3'(sda_pkg::MUL_STEPS)) begin
                    n_pp  = SW'(w_ma_part) * SW'(w_mb_part);
                    n_psh = 2'(r_mcnt[1]) + 2'(r_mcnt[0]);
                end
                if (r_mcnt != '0) begin
                    n_acc = r_acc + (WW'(r_pp) << {r_psh, 5'd0});
                end
                n_mcnt = r_mcnt + 3'd1;
            end
            sda_pkg::S_DIV: begin
                n_dvd  = r_dvd << 1;
                n_rem  = w_take ? (w_remn[SW-1:0] - r_dvs) : w_remn[SW-1:0];
                n_quo  = {r_quo[WW-2:0], w_take};
                n_dcnt = r_dcnt + 7'd1;
            end
            sda_pkg::S_NEXT: begin
                n_mcnt = '0;
                n_acc  = '0;
                n_rem  = '0;
                n_quo  = '0;
                n_dcnt = '0;
                case (r_step)
                    sda_pkg::ST_SPLIT: begin
                        n_psplit = sda_pkg::sat_scale(r_acc >> sda_pkg::RATIO_FRAC_BITS);
                    end
                    sda_pkg::ST_CMUL: begin
                        n_step = sda_pkg::ST_CDIV;
                        n_dvd  = r_acc;
                        n_dvs  = SW'(w_den);
                    end
                    sda_pkg::ST_CDIV: begin
                        n_step = sda_pkg::ST_SDIV;
                        n_dvd  = WW'(w_q) << sda_pkg::SCALE_FRAC_BITS;
                        n_dvs  = r_psplit;
                    end
                    sda_pkg::ST_SDIV: begin
                        n_step = sda_pkg::ST_VMUL;
                        n_newp = w_q;
                        n_ma   = r_vscale;
                        n_mb   = r_psplit;
                    end
                    sda_pkg::ST_VMUL: begin
                        n_vscale = sda_pkg::sat_scale(r_acc >> sda_pkg::SCALE_FRAC_BITS);
                        n_pscale = r_newp;
                        n_step   = sda_pkg::ST_OPEN;
                        n_ma     = SW'(r_item.open_price);
                        n_mb     = r_newp;
                    end
                    sda_pkg::ST_OPEN: begin
                        n_res_open = sda_pkg::sat_price(r_acc >> sda_pkg::SCALE_FRAC_BITS);
                        n_step     = sda_pkg::ST_HIGH;
                        n_ma       = SW'(r_item.high_price);
                        n_mb       = r_pscale;
                    end
                    sda_pkg::ST_HIGH: begin
                        n_res_high = sda_pkg::sat_price(r_acc >> sda_pkg::SCALE_FRAC_BITS);
                        n_step     = sda_pkg::ST_LOW;
                        n_ma       = SW'(r_item.low_price);
                        n_mb       = r_pscale;
                    end
                    sda_pkg::ST_LOW: begin
                        n_res_low = sda_pkg::sat_price(r_acc >> sda_pkg::SCALE_FRAC_BITS);
                        n_step    = sda_pkg::ST_CLOSE;
                        n_ma      = SW'(r_item.close_price);
                        n_mb      = r_pscale;
                    end
                    sda_pkg::ST_CLOSE: begin
                        n_res_close = sda_pkg::sat_price(r_acc >> sda_pkg::SCALE_FRAC_BITS);
                        n_step      = sda_pkg::ST_VOL;
                        n_ma        = SW'(r_item.share_volume);
                        n_mb        = r_vscale;
                    end
                    default: begin
                        n_res_vol = sda_pkg::sat_vol(r_acc >> sda_pkg::SCALE_FRAC_BITS);
                    end
                endcase
            end
            sda_pkg::S_OUT: begin
                if (w_out_free) begin
                    n_ovalid  = 1'b1;
                    n_o_open  = r_res_open;
                    n_o_high  = r_res_high;
                    n_o_low   = r_res_low;
                    n_o_close = r_res_close;
                    n_o_vol   = r_res_vol;
                    n_o_fault = r_fault;
                    n_prior   = r_item.close_price;
                    n_cash    = '0;
                    n_psplit  = sda_pkg::SCALE_ONE;
                end
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sda_pkg::S_IDLE;
            r_ovalid <= 1'b0;
            r_prior  <= '0;
            r_cash   <= '0;
            r_psplit <= sda_pkg::SCALE_ONE;
            r_pscale <= sda_pkg::SCALE_ONE;
            r_vscale <= sda_pkg::SCALE_ONE;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_prior  <= n_prior;
            r_cash   <= n_cash;
            r_psplit <= n_psplit;
            r_pscale <= n_pscale;
            r_vscale <= n_vscale;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step      <= n_step;
        r_item      <= n_item;
        r_fault     <= n_fault;
        r_newp      <= n_newp;
        r_ma        <= n_ma;
        r_mb        <= n_mb;
        r_mcnt      <= n_mcnt;
        r_pp        <= n_pp;
        r_psh       <= n_psh;
        r_acc       <= n_acc;
        r_dvd       <= n_dvd;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_dvs       <= n_dvs;
        r_dcnt      <= n_dcnt;
        r_res_open  <= n_res_open;
        r_res_high  <= n_res_high;
        r_res_low   <= n_res_low;
        r_res_close <= n_res_close;
        r_res_vol   <= n_res_vol;
        r_o_open    <= n_o_open;
        r_o_high    <= n_o_high;
        r_o_low     <= n_o_low;
        r_o_close   <= n_o_close;
        r_o_vol     <= n_o_vol;
        r_o_fault   <= n_o_fault;
    end

    assign o_valid      = r_ovalid;
    assign o_adj_open   = r_o_open;
    assign o_adj_high   = r_o_high;
    assign o_adj_low    = r_o_low;
    assign o_adj_close  = r_o_close;
    assign o_adj_volume = r_o_vol;
    assign o_fault      = r_o_fault;

endmodule

// ===== rtl/split_dividend_back_adjuster.sv =====
// ----------------------------------------------------------------------------
// split_dividend_back_adjuster
// back-adjusts a newest-first bar stream for cash distributions and splits
// ----------------------------------------------------------------------------
// throughput: one queued beat at a time; bars are set by the 1-bit-per-cycle
//   divider and the 4-pass 32x32 multiplier
// reset: synchronous active-low; clears queue, output valid and the factors
// ----------------------------------------------------------------------------
module split_dividend_back_adjuster (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // open[39:0] high[79:40] low[119:80] close[159:120] volume[207:160]
    // cash[239:208] split[271:240]
    input  logic [271:0]  s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // adj_open[39:0] adj_high[79:40] adj_low[119:80] adj_close[159:120]
    // adj_volume[207:160]
    output logic [207:0]  m_axis_tdata,
    // fault[1:0]
    output logic [1:0]    m_axis_tuser
);

    // queue head passed from the front to the back
    sda_pkg::t_qhead w_head;
    logic            w_pop;

    // front: takes beats while its queue has room, drops early events and unused modes
    sda_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_mode         (s_axis_tuser),
        .i_open_price   (s_axis_tdata[39:0]),
        .i_high_price   (s_axis_tdata[79:40]),
        .i_low_price    (s_axis_tdata[119:80]),
        .i_close_price  (s_axis_tdata[159:120]),
        .i_share_volume (s_axis_tdata[207:160]),
        .i_cash_amount  (s_axis_tdata[239:208]),
        .i_split_ratio  (s_axis_tdata[271:240]),
        .o_head         (w_head),
        .i_pop          (w_pop)
    );

    // back: factor update, scaling, output register
    sda_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_adj_open   (m_axis_tdata[39:0]),
        .o_adj_high   (m_axis_tdata[79:40]),
        .o_adj_low    (m_axis_tdata[119:80]),
        .o_adj_close  (m_axis_tdata[159:120]),
        .o_adj_volume (m_axis_tdata[207:160]),
        .o_fault      (m_axis_tuser)
    );

endmodule

// ===== rtl/sda_checker.sv =====
// ----------------------------------------------------------------------------
// sda_checker
// port-level checks for the back adjuster
// ----------------------------------------------------------------------------
module sda_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    input  logic [271:0]  s_axis_tdata,
    input  logic [1:0]    s_axis_tuser,
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [207:0]  m_axis_tdata,
    input  logic [1:0]    m_axis_tuser
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // fault code is never the unused value
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("unused fault code");

    // reset empties the output register
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // reset empties the queue, so input is ready
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind split_dividend_back_adjuster sda_checker u_sda_checker (.*);

// ===== tb/sv/sda_checker.sv =====
// ----------------------------------------------------------------------------
// sda_scoreboard
// watches both stream channels of the back adjuster, predicts each restated
// bar from the accepted input beats and compares it with the output beats
// ----------------------------------------------------------------------------
module sda_scoreboard (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_s_tready,
    input  logic [271:0]  i_s_tdata,
    input  logic [1:0]    i_s_tuser,
    input  logic          i_m_tvalid,
    input  logic          i_m_tready,
    input  logic [207:0]  i_m_tdata,
    input  logic [1:0]    i_m_tuser,
    output int            o_errors,
    output int            o_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PB = sda_pkg::PRICE_BITS;
    localparam int VB = sda_pkg::VOL_BITS;
    localparam int CB = sda_pkg::CASH_BITS;

    typedef struct packed {
        logic [PB-1:0]   adj_open;
        logic [PB-1:0]   adj_high;
        logic [PB-1:0]   adj_low;
        logic [PB-1:0]   adj_close;
        logic [VB-1:0]   adj_volume;
        sda_pkg::t_fault fault;
    } t_adj_bar;

    localparam logic signed [CB:0] CASH_HI = (41'sd1 <<< (CB - 1)) - 41'sd1;
    localparam logic signed [CB:0] CASH_LO = -(41'sd1 <<< (CB - 1));

    logic                               bar_seen;
    logic [PB-1:0]                      last_close;
    logic signed [CB-1:0]               cash_sum;
    logic [sda_pkg::SCALE_BITS-1:0]     split_acc;
    logic [sda_pkg::SCALE_BITS-1:0]     px_scale;
    logic [sda_pkg::SCALE_BITS-1:0]     vol_scale;
    t_adj_bar                           adj_bars_due[$];

    assign o_waiting = adj_bars_due.size();

    function automatic logic [63:0] clamp64(input logic [127:0] v);
        return (v[127:64] != '0) ? '1 : v[63:0];
    endfunction

    // floor(x * scale / 2^48) clamped at the given field width
    function automatic logic [63:0] restate(input logic [63:0] x, input logic [63:0] scale,
                                            input int bits);
        logic [127:0] w;
        w = (128'(x) * 128'(scale)) >> sda_pkg::SCALE_FRAC_BITS;
        if (w >> bits != 0) return (64'd1 << bits) - 64'd1;
        return w[63:0];
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] mismatch %s: got 0x%0h expected 0x%0h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        logic [PB-1:0]                      op, hp, lp, cp;
        logic [VB-1:0]                      vol;
        logic signed [sda_pkg::AMT_BITS-1:0] amt;
        logic [sda_pkg::RATIO_BITS-1:0]     ratio;
        logic signed [CB:0]                 csum;
        logic signed [CB+1:0]               den;
        logic [127:0]                       w;
        logic [63:0]                        q;
        sda_pkg::t_fault                    flt;
        t_adj_bar                           exp_bar, got_bar;

        if (!i_rst_n) begin
            bar_seen   <= 1'b0;
            last_close <= '0;
            cash_sum   <= '0;
            split_acc  <= sda_pkg::SCALE_ONE;
            px_scale   = sda_pkg::SCALE_ONE;
            vol_scale  = sda_pkg::SCALE_ONE;
            adj_bars_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                {ratio, amt, vol, cp, lp, hp, op} = i_s_tdata;
                case (sda_pkg::t_mode'(i_s_tuser))
                    sda_pkg::MODE_CASH: if (bar_seen) begin
                        csum = cash_sum + amt;
                        if (csum > CASH_HI) csum = CASH_HI;
                        if (csum < CASH_LO) csum = CASH_LO;
                        cash_sum <= csum[CB-1:0];
                    end
                    sda_pkg::MODE_SPLIT: if (bar_seen) begin
                        w = (128'(split_acc) * 128'(ratio)) >> sda_pkg::RATIO_FRAC_BITS;
                        split_acc <= clamp64(w);
                    end
                    sda_pkg::MODE_BAR: begin
                        flt = sda_pkg::FAULT_OK;
                        exp_bar.adj_open = '0; // keeps the struct fully assigned
                        if (bar_seen) begin
                            q = px_scale;
                            if (split_acc == '0) begin
                                flt = sda_pkg::FAULT_SPLIT;
                            end else if (cash_sum != '0) begin
                                den = cash_sum + $signed({2'b00, last_close});
                                if (last_close == '0 || den <= 0)
                                    flt = sda_pkg::FAULT_CLOSE;
                                else
                                    q = clamp64((128'(px_scale) * 128'(last_close))
                                                / 128'(den[CB:0]));
                            end
                            if (flt == sda_pkg::FAULT_OK) begin
                                px_scale  = clamp64((128'(q) << sda_pkg::SCALE_FRAC_BITS)
                                                    / 128'(split_acc));
                                vol_scale = clamp64((128'(vol_scale) * 128'(split_acc))
                                                    >> sda_pkg::SCALE_FRAC_BITS);
                            end
                        end
                        bar_seen   <= 1'b1;
                        cash_sum   <= '0;
                        split_acc  <= sda_pkg::SCALE_ONE;
                        last_close <= cp;
                        exp_bar.adj_open   = PB'(restate(64'(op), px_scale, PB));
                        exp_bar.adj_high   = PB'(restate(64'(hp), px_scale, PB));
                        exp_bar.adj_low    = PB'(restate(64'(lp), px_scale, PB));
                        exp_bar.adj_close  = PB'(restate(64'(cp), px_scale, PB));
                        exp_bar.adj_volume = VB'(restate(64'(vol), vol_scale, VB));
                        exp_bar.fault      = flt;
                        adj_bars_due.push_back(exp_bar);
                    end
                    default: ;
                endcase
            end

            if (i_m_tvalid && i_m_tready) begin
                {got_bar.adj_volume, got_bar.adj_close, got_bar.adj_low,
                 got_bar.adj_high, got_bar.adj_open} = i_m_tdata;
                got_bar.fault = sda_pkg::t_fault'(i_m_tuser);
                if (adj_bars_due.size() == 0) begin
                    report("unexpected bar", 64'(got_bar.adj_close), '0);
                end else begin
                    exp_bar = adj_bars_due.pop_front();
                    if (got_bar.adj_open != exp_bar.adj_open)
                        report("adj_open", 64'(got_bar.adj_open), 64'(exp_bar.adj_open));
                    if (got_bar.adj_high != exp_bar.adj_high)
                        report("adj_high", 64'(got_bar.adj_high), 64'(exp_bar.adj_high));
                    if (got_bar.adj_low != exp_bar.adj_low)
                        report("adj_low", 64'(got_bar.adj_low), 64'(exp_bar.adj_low));
                    if (got_bar.adj_close != exp_bar.adj_close)
                        report("adj_close", 64'(got_bar.adj_close), 64'(exp_bar.adj_close));
                    if (got_bar.adj_volume != exp_bar.adj_volume)
                        report("adj_volume", 64'(got_bar.adj_volume),
                               64'(exp_bar.adj_volume));
                    if (got_bar.fault != exp_bar.fault)
                        report("fault", 64'(got_bar.fault), 64'(exp_bar.fault));
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// drives bar, cash and split beats into the back adjuster under varying
// back-pressure; the checker predicts and compares, this module gives verdict
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1700;
    localparam int STALL_LIMIT  = 20000;   // idle cycles with no beat on either side
    localparam int DRAIN_CYCLES = 400;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [271:0]  s_axis_tdata = '0;     // open, high, low, close, volume, cash, split
    logic [1:0]    s_axis_tuser = '0;     // mode
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [207:0]  m_axis_tdata;          // adj open, high, low, close, volume
    logic [1:0]    m_axis_tuser;          // fault

    int tx_idle_pct = 35;
    int rx_idle_pct = 80;
    int errors;
    int waiting;
    int quiet_cycles = 0;

    split_dividend_back_adjuster dut (.*);

    sda_scoreboard chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .o_errors   (errors),
        .o_waiting  (waiting)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // watchdog: ends the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [39:0] rnd40();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[39:0];
    endfunction

    function automatic logic [47:0] rnd48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[47:0];
    endfunction

    // one beat, held until accepted; random gaps in front of it
    task automatic push_beat(input sda_pkg::t_mode mode, input logic [39:0] op,
                             input logic [39:0] hp, input logic [39:0] lp,
                             input logic [39:0] cp, input logic [47:0] vol,
                             input logic [31:0] cash, input logic [31:0] ratio);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {ratio, cash, vol, cp, lp, hp, op};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // bar with random unused fields
    task automatic push_bar(input logic [39:0] op, input logic [39:0] hp, input logic [39:0] lp,
                            input logic [39:0] cp, input logic [47:0] vol);
        push_beat(sda_pkg::MODE_BAR, op, hp, lp, cp, vol, $urandom, $urandom);
    endtask

    task automatic push_cash(input logic [31:0] cash);
        push_beat(sda_pkg::MODE_CASH, rnd40(), rnd40(), rnd40(), rnd40(), rnd48(), cash,
                  $urandom);
    endtask

    task automatic push_split(input logic [31:0] ratio);
        push_beat(sda_pkg::MODE_SPLIT, rnd40(), rnd40(), rnd40(), rnd40(), rnd48(), $urandom,
                  ratio);
    endtask

    // a realistic bar around a random close, sometimes full range
    task automatic push_random_bar();
        logic [39:0] cp;
        logic [47:0] vol;
        if ($urandom_range(99) < 20) begin
            push_bar(rnd40(), rnd40(), rnd40(), rnd40(), rnd48());
        end else begin
            cp  = 40'($urandom_range(32'h00FF_FFFF, 1));
            vol = 48'($urandom_range(32'h0FFF_FFFF, 0));
            push_bar(cp + 40'($urandom_range(500)), cp + 40'($urandom_range(1000)),
                     cp - 40'($urandom_range(500)), cp, vol);
        end
    endtask

    task automatic push_random_event();
        int pick;
        pick = $urandom_range(99);
        if (pick < 35)
            push_cash($urandom_range(20000, 1));
        else if (pick < 45)
            push_cash(-$urandom_range(5000, 1));
        else if (pick < 55)
            push_cash($urandom);
        else if (pick < 85)
            push_split($urandom_range(32'h0004_0000, 32'h0000_4000));
        else if (pick < 97)
            push_split($urandom);
        else
            push_split('0);
    endtask

    initial begin
        int n;
        int events;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: events ahead of the first bar are dropped
        push_cash(32'd5000);
        push_split(32'h0002_0000);
        push_beat(sda_pkg::MODE_NONE, rnd40(), rnd40(), rnd40(), rnd40(), rnd48(),
                  $urandom, $urandom);
        // first bar, every field at its maximum
        push_bar('1, '1, '1, '1, '1);
        // ordinary two-for-one split with cash
        push_split(32'h0002_0000);
        push_cash(32'd1000);
        push_bar(40'd1000000, 40'd1010000, 40'd990000, 40'd1000000, 48'd123456);
        // zero split ratio gives a split fault
        push_split('0);
        push_bar(40'd2000000, 40'd2000000, 40'd2000000, 40'd0, 48'd1000);
        // cash against a zero prior close gives a close fault
        push_cash(32'd100);
        push_bar(40'd300000, 40'd300000, 40'd300000, 40'd0, 48'd1000);
        // zero close without cash: ratio counts as one
        push_bar(40'd400000, 40'd410000, 40'd390000, 40'd500, 48'd2000);
        // cash cancelling the close: denominator zero
        push_cash(-32'sd500);
        push_bar(40'd500, 40'd500, 40'd500, 40'd500, 48'd3000);
        // largest ratios saturate the split product and the volume
        push_split('1);
        push_split('1);
        push_split('1);
        push_cash(32'h7FFF_FFFF);
        push_cash(32'h8000_0000);
        push_bar(40'd700000, 40'd700000, 40'd700000, 40'd700000, '1);
        // tiny ratios shrink the split product far below one
        push_split(32'd1);
        push_split(32'd1);
        push_bar('0, '0, '0, '0, '0);
        push_bar(40'd100, 40'd100, 40'd100, 40'd100, 48'd100);

        // random: bars followed by their events, with some noise
        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 80 : 0;
            rx_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 35 : 0;
            n = 0;
            while (n < RANDOM_ITEMS / 3) begin
                if ($urandom_range(99) < 4) begin
                    push_beat(sda_pkg::MODE_NONE, rnd40(), rnd40(), rnd40(), rnd40(),
                              rnd48(), $urandom, $urandom);
                end else begin
                    push_random_bar();
                    events = $urandom_range(3);
                    for (int k = 0; k < events; k++) push_random_event();
                    n += events;
                end
                n++;
            end
        end
        s_axis_tvalid <= 1'b0;

        while (waiting != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
